// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

    // Pending sequence length codes (held in a 3-bit register)
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 3;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET  = 21'h10000;
    localparam logic [20:0] MAX_CODE     = 21'h10FFFF;

    // Units produced by one input byte: zero, one or two, in order
    typedef struct packed {
        logic [1:0]  n;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_units;

endpackage

// File: rtl/u8u16_decode.sv
module u8u16_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output u8u16_pkg::t_units    o_units
);

    logic [2:0] r_len, n_len;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_h0, r_h1, r_h2;
    logic [7:0] n_h0, n_h1, n_h2;
    logic [2:0] cnt_new;
    u8u16_pkg::t_units res;

    function automatic logic is_cont(input logic [7:0] b);
        is_cont = (b[7:6] == 2'b10);
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] l;
        l = u8u16_pkg::LEN_NONE;
        if (b[7:5] == 3'b110) begin
            l = u8u16_pkg::LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            l = u8u16_pkg::LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
            l = u8u16_pkg::LEN_FOUR;
        end
        lead_len = l;
    endfunction

    function automatic u8u16_pkg::t_units one_unit(input logic [15:0] u);
        u8u16_pkg::t_units r;
        r = '0;
        r.n = 2'd1;
        r.u0 = u;
        one_unit = r;
    endfunction

    function automatic logic [15:0] two_byte(input logic [7:0] a, input logic [7:0] b);
        two_byte = {5'd0, a[4:0], b[5:0]};
    endfunction

    // Complete sequence: a is the lead, b..d the following bytes as needed
    function automatic u8u16_pkg::t_units full_seq(input logic [2:0] len,
                                                 input logic [7:0] a,
                                                 input logic [7:0] b,
                                                 input logic [7:0] c,
                                                 input logic [7:0] d);
        u8u16_pkg::t_units r;
        logic [20:0] cp;
        logic [20:0] v;
        r = '0;
        cp = '0;
        v = '0;
        unique case (len)
            u8u16_pkg::LEN_TWO: begin
                r = one_unit(two_byte(a, b));
            end
            u8u16_pkg::LEN_THREE: begin
                if (is_cont(b) && is_cont(c)) begin
                    r = one_unit({a[3:0], b[5:0], c[5:0]});
                end else begin
                    r = one_unit(16'h0000);
                end
            end
            u8u16_pkg::LEN_FOUR: begin
                cp = {a[2:0], b[5:0], c[5:0], d[5:0]};
                v = cp - u8u16_pkg::SUPP_OFFSET;
                if (!(is_cont(b) && is_cont(c) && is_cont(d))) begin
                    r = one_unit(16'h0000);
                end else if (cp[20:16] == 5'd0) begin
                    r = one_unit(cp[15:0]);
                end else if (cp <= u8u16_pkg::MAX_CODE) begin
                    r.n = 2'd2;
                    r.u0 = u8u16_pkg::HI_SURR_BASE + {6'd0, v[19:10]};
                    r.u1 = u8u16_pkg::LO_SURR_BASE + {6'd0, v[9:0]};
                end
            end
            default: begin
                r = '0;
            end
        endcase
        full_seq = r;
    endfunction

    // End-of-string rescan of the bytes after the dropped lead
    function automatic u8u16_pkg::t_units tail_seq(input logic two,
                                                 input logic [7:0] a,
                                                 input logic [7:0] b);
        u8u16_pkg::t_units r;
        r = '0;
        if (!two) begin
            if (!b[7]) r = one_unit({8'd0, b});
        end else if (!a[7]) begin
            r.u0 = {8'd0, a};
            if (!b[7]) begin
                r.n = 2'd2;
                r.u1 = {8'd0, b};
            end else begin
                r.n = 2'd1;
            end
        end else if (a[7:5] == 3'b110) begin
            r = one_unit(two_byte(a, b));
        end else if (!b[7]) begin
            r = one_unit({8'd0, b});
        end
        tail_seq = r;
    endfunction

    always_comb begin
        n_len = r_len;
        n_cnt = r_cnt;
        n_h0 = r_h0;
        n_h1 = r_h1;
        n_h2 = r_h2;
        res = '0;
        cnt_new = {1'b0, r_cnt} + 3'd1;
        if (r_len == u8u16_pkg::LEN_NONE) begin
            if (!i_byte[7]) begin
                res = one_unit({8'd0, i_byte});
            end else if ((lead_len(i_byte) != u8u16_pkg::LEN_NONE) && !i_end) begin
                n_h0 = i_byte;
                n_cnt = 2'd1;
                n_len = lead_len(i_byte);
            end
        end else if (cnt_new >= r_len) begin
            unique case (r_len)
                u8u16_pkg::LEN_TWO:   res = full_seq(r_len, r_h0, i_byte, 8'd0, 8'd0);
                u8u16_pkg::LEN_THREE: res = full_seq(r_len, r_h0, r_h1, i_byte, 8'd0);
                default:              res = full_seq(r_len, r_h0, r_h1, r_h2, i_byte);
            endcase
            n_len = u8u16_pkg::LEN_NONE;
            n_cnt = 2'd0;
        end else if (i_end) begin
            res = tail_seq(r_cnt == 2'd2, r_h1, i_byte);
        end else begin
            if (r_cnt == 2'd1) begin
                n_h1 = i_byte;
            end else begin
                n_h2 = i_byte;
            end
            n_cnt = cnt_new[1:0];
        end
        if (i_end) begin
            n_len = u8u16_pkg::LEN_NONE;
            n_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= u8u16_pkg::LEN_NONE;
            r_cnt <= 2'd0;
        end else if (i_take) begin
            r_len <= n_len;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            r_h2 <= n_h2;
        end
    end

    assign o_units = res;

endmodule

// File: rtl/utf8_to_utf16_stream.sv
// UTF-8 to UTF-16 stream transcoder. Takes one UTF-8 byte per transfer on
// the slave side (tlast marks the final byte of a string) and delivers the
// UTF-16 code units it completes on the master side, tlast set on the final
// unit caused by each byte. ASCII passes through; two-byte sequences combine
// without checking the second byte; three- and four-byte sequences with a
// bad continuation byte give a single 0x0000; values above 0x10FFFF give no
// unit; values above 0xFFFF become a surrogate pair. Stray continuation bytes
// and invalid leads are dropped. If the string ends inside a sequence, the
// lead is dropped and the following bytes are rescanned as a string tail.
// Rate: one byte per cycle while ready is high; a byte is decoded in the
// cycle it is accepted and its units land in a three-entry output queue.
// Ready depends only on the registered queue count and is high while the
// queue holds at most one unit, so a stream that yields one unit per byte
// runs at one transfer per cycle while the master side accepts, and each
// surrogate pair drops ready (the single output port drains one unit a cycle).
module utf8_to_utf16_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // string_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast    // run_last
);

    localparam int unsigned QD = u8u16_pkg::QUEUE_DEPTH;

    logic              take;
    logic              pop;
    u8u16_pkg::t_units units;

    logic [15:0] r_q_unit [QD];
    logic        r_q_last [QD];
    logic [15:0] n_q_unit [QD];
    logic        n_q_last [QD];
    logic [1:0]  r_q_cnt, n_q_cnt;
    logic [1:0]  base;

    // Accept a byte only while the queue has room for a surrogate pair
    assign s_axis_tready = (r_q_cnt < 2'd2);
    assign take = s_axis_tvalid && s_axis_tready;

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .o_units (units)
    );

    assign m_axis_tvalid = (r_q_cnt != 2'd0);
    assign m_axis_tdata  = r_q_unit[0];
    assign m_axis_tlast  = r_q_last[0];
    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb begin
        // Advance the queue on a pop, then append the new units behind it
        base = r_q_cnt - {1'b0, pop};
        for (int k = 0; k < QD; k++) begin
            if (pop && (k < QD - 1)) begin
                n_q_unit[k] = r_q_unit[k + 1];
                n_q_last[k] = r_q_last[k + 1];
            end else begin
                n_q_unit[k] = r_q_unit[k];
                n_q_last[k] = r_q_last[k];
            end
            if (take && (units.n != 2'd0) && (2'(k) == base)) begin
                n_q_unit[k] = units.u0;
                n_q_last[k] = (units.n == 2'd1);
            end
            if (take && (units.n == 2'd2) && (2'(k) == base + 2'd1)) begin
                n_q_unit[k] = units.u1;
                n_q_last[k] = 1'b1;
            end
        end
        n_q_cnt = base + (take ? units.n : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    // Hold payload in place; only the count needs reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QD; k++) begin
            r_q_unit[k] <= n_q_unit[k];
            r_q_last[k] <= n_q_last[k];
        end
    end

endmodule
